// ----- hw/rtl/quoted_token_splitter_assert.svh -----
// Assertion macros shared by the quoted token splitter modules.
`ifndef QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define QTS_ASSERT_NOW(label, cond_a, cond_b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define QTS_ASSERT_NEXT(label, cond_a, cond_b, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_b)) \
      else $error(msg);

`endif

// ----- hw/rtl/qts_pkg.sv -----
// Types, constants and helpers shared by the quoted token splitter.
`timescale 1ns / 1ps

package qts_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int DCOUNT_W    = 3;

   localparam logic [BYTE_W-1:0] BACKSLASH_CHAR = 8'd92;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_A     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_B     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_C     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_D     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE_CHAR  = 3'd5;

   // Register reset values
   localparam logic [BYTE_W-1:0]   DELIM_A_RESET     = 8'd32;
   localparam logic [BYTE_W-1:0]   DELIM_B_RESET     = 8'd9;
   localparam logic [BYTE_W-1:0]   DELIM_C_RESET     = 8'd13;
   localparam logic [BYTE_W-1:0]   DELIM_D_RESET     = 8'd10;
   localparam logic [DCOUNT_W-1:0] DELIM_COUNT_RESET = 3'd4;
   localparam logic [BYTE_W-1:0]   QUOTE_CHAR_RESET  = 8'd34;

   typedef enum logic [1:0] {
      MODE_SKIP   = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2
   } scan_mode_type;

   // One result word without its end-of-item flag
   typedef struct packed {
      logic [BYTE_W-1:0] token_byte;
      logic              byte_valid;
      logic              token_end;
   } rsp_word_type;

   // One queued item: one or two result words
   typedef struct packed {
      logic         two;
      rsp_word_type r0;
      rsp_word_type r1;
   } entry_type;

   function automatic rsp_word_type byte_word(input logic [BYTE_W-1:0] b);
      rsp_word_type w;
      w.token_byte = b;
      w.byte_valid = 1'b1;
      w.token_end  = 1'b0;
      return w;
   endfunction

   function automatic rsp_word_type end_word();
      rsp_word_type w;
      w.token_byte = '0;
      w.byte_valid = 1'b0;
      w.token_end  = 1'b1;
      return w;
   endfunction

endpackage

// ----- hw/rtl/qts_chan_if.sv -----
// Handshake channel interfaces for the splitter's input and result words.
`timescale 1ns / 1ps

interface qts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       string_end;

   modport source (output valid, output text_byte, output string_end, input ready);
   modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface qts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_byte;
   logic       byte_valid;
   logic       token_end;
   logic       last_of_item;

   modport source (output valid, output token_byte, output byte_valid,
                   output token_end, output last_of_item, input ready);
   modport sink   (input valid, input token_byte, input byte_valid,
                   input token_end, input last_of_item, output ready);
endinterface

// ----- hw/rtl/qts_front.sv -----
// Front end: configuration registers, byte classification and scan state machine.
`timescale 1ns / 1ps
`include "quoted_token_splitter_assert.svh"

module qts_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [qts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qts_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   input  logic                              req_valid,
   input  logic [qts_pkg::BYTE_W-1:0]        text_byte,
   input  logic                              string_end,
   output logic                              req_ready,
   input  logic                              queue_ready,
   output logic                              push_valid,
   output qts_pkg::entry_type                push_entry
);
   import qts_pkg::*;

   logic [BYTE_W-1:0]   delim_a_ff, delim_b_ff, delim_c_ff, delim_d_ff, quote_char_ff;
   logic [DCOUNT_W-1:0] delim_count_ff;
   scan_mode_type       mode_ff, mode_in;
   logic                esc_ff, esc_in;

   logic       accept;
   logic       is_delim, quote_on, is_quote, is_bs, q_is_bs;
   logic [1:0] result_count;
   rsp_word_type r0, r1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_a_ff     <= DELIM_A_RESET;
         delim_b_ff     <= DELIM_B_RESET;
         delim_c_ff     <= DELIM_C_RESET;
         delim_d_ff     <= DELIM_D_RESET;
         delim_count_ff <= DELIM_COUNT_RESET;
         quote_char_ff  <= QUOTE_CHAR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELIM_A:     delim_a_ff     <= csr_wr_data;
            CSR_DELIM_B:     delim_b_ff     <= csr_wr_data;
            CSR_DELIM_C:     delim_c_ff     <= csr_wr_data;
            CSR_DELIM_D:     delim_d_ff     <= csr_wr_data;
            CSR_DELIM_COUNT: delim_count_ff <= csr_wr_data[DCOUNT_W-1:0];
            CSR_QUOTE_CHAR:  quote_char_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = queue_ready;
   assign accept    = req_valid && queue_ready;

   // Classify the incoming byte; counts above four act as four
   assign is_delim = ((delim_count_ff >= 3'd1) && (text_byte == delim_a_ff))
                  || ((delim_count_ff >= 3'd2) && (text_byte == delim_b_ff))
                  || ((delim_count_ff >= 3'd3) && (text_byte == delim_c_ff))
                  || ((delim_count_ff >= 3'd4) && (text_byte == delim_d_ff));
   assign quote_on = (quote_char_ff != '0);
   assign is_quote = (text_byte == quote_char_ff);
   assign is_bs    = (text_byte == BACKSLASH_CHAR);
   assign q_is_bs  = (quote_char_ff == BACKSLASH_CHAR);

   // Next scan state
   always_comb begin
      mode_in = mode_ff;
      esc_in  = esc_ff;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (string_end || is_delim) mode_in = MODE_SKIP;
         end
         MODE_QUOTED: begin
            if (string_end) begin
               mode_in = MODE_SKIP;
               esc_in  = 1'b0;
            end else if (esc_ff) begin
               esc_in = 1'b0;
               if (is_quote) begin
                  mode_in = MODE_QUOTED;
               end else if (q_is_bs) begin
                  // held escape closes the token; this byte may open a plain one
                  mode_in = is_delim ? MODE_SKIP : MODE_PLAIN;
               end else if (is_bs) begin
                  esc_in = 1'b1;
               end
            end else if (is_bs) begin
               esc_in = 1'b1;
            end else if (is_quote) begin
               mode_in = MODE_SKIP;
            end
         end
         default: begin
            mode_in = MODE_SKIP;
            esc_in  = 1'b0;
            if (!string_end && !is_delim) begin
               mode_in = (quote_on && is_quote) ? MODE_QUOTED : MODE_PLAIN;
            end
         end
      endcase
   end

   // Result words caused by this byte
   always_comb begin
      result_count = 2'd0;
      r0           = end_word();
      r1           = end_word();
      unique case (mode_ff)
         MODE_PLAIN: begin
            result_count = 2'd1;
            if (!(string_end || is_delim)) r0 = byte_word(text_byte);
         end
         MODE_QUOTED: begin
            if (string_end) begin
               if (esc_ff && !q_is_bs) begin
                  result_count = 2'd2;
                  r0           = byte_word(BACKSLASH_CHAR);
               end else begin
                  result_count = 2'd1;
               end
            end else if (esc_ff) begin
               if (is_quote) begin
                  result_count = 2'd1;
                  r0           = byte_word(text_byte);
               end else if (q_is_bs) begin
                  result_count = is_delim ? 2'd1 : 2'd2;
                  r1           = byte_word(text_byte);
               end else begin
                  r0           = byte_word(BACKSLASH_CHAR);
                  result_count = is_bs ? 2'd1 : 2'd2;
                  r1           = byte_word(text_byte);
               end
            end else if (is_bs) begin
               result_count = 2'd0;
            end else begin
               result_count = 2'd1;
               if (!is_quote) r0 = byte_word(text_byte);
            end
         end
         default: begin
            if (!string_end && !is_delim && !(quote_on && is_quote)) begin
               result_count = 2'd1;
               r0           = byte_word(text_byte);
            end
         end
      endcase
   end

   assign push_valid    = accept && (result_count != 2'd0);
   assign push_entry.two = (result_count == 2'd2);
   assign push_entry.r0  = r0;
   assign push_entry.r1  = r1;

   // Advance scan state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
         esc_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
      end
   end

   `QTS_ASSERT_NOW(a_esc_only_quoted, esc_ff, mode_ff == MODE_QUOTED, "escape held outside quoted token")
   `QTS_ASSERT_NOW(a_end_word_shape, push_valid && !push_entry.r0.byte_valid, push_entry.r0.token_end && (push_entry.r0.token_byte == '0), "bad end marker")

endmodule

// ----- hw/rtl/qts_queue.sv -----
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`include "quoted_token_splitter_assert.svh"

module qts_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  qts_pkg::entry_type push_entry,
   output logic               push_ready,
   output logic               head_valid,
   output qts_pkg::entry_type head_entry,
   input  logic               pop
);
   import qts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) slots[wr_ptr_ff] <= push_entry;
   end

   `QTS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_CNT, "queue count beyond depth")
   `QTS_ASSERT_NOW(a_no_push_full, push_valid, count_ff != FULL_CNT, "push into full queue")

endmodule

// ----- hw/rtl/qts_back.sv -----
// Back end: unpacks queued items into result words behind an output register.
`timescale 1ns / 1ps
`include "quoted_token_splitter_assert.svh"

module qts_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  qts_pkg::entry_type    head_entry,
   output logic                  pop,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output qts_pkg::rsp_word_type rsp_word,
   output logic                  rsp_last
);
   import qts_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type word_ff, word_in;
   logic         last_ff, last_in;
   logic         sel_ff, sel_in;
   logic         load;

   assign load = !rsp_valid_ff || rsp_ready;

   // Load the next word; drop the head entry after its last word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      sel_in       = sel_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            word_in = sel_ff ? head_entry.r1 : head_entry.r0;
            last_in = !head_entry.two || sel_ff;
            if (head_entry.two && !sel_ff) begin
               sel_in = 1'b1;
            end else begin
               sel_in = 1'b0;
               pop    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = word_ff;
   assign rsp_last  = last_ff;

   `QTS_ASSERT_NEXT(a_second_word_follows, rsp_valid_ff && rsp_ready && !last_ff, rsp_valid_ff, "second word of item missing")
   `QTS_ASSERT_NOW(a_pop_needs_head, pop, head_valid, "pop from empty queue")

endmodule

// ----- hw/rtl/quoted_token_splitter.sv -----
// Top level of the quoted token splitter.
`timescale 1ns / 1ps
// Splits a byte stream into tokens separated by up to four delimiter bytes,
// with optional quoted tokens (backslash escapes the quote byte).
// req_chan: one text byte per word, or a string-end mark that closes any token.
// rsp_chan: token bytes as they arrive, each token closed by an end marker
//   word; last_of_item flags the final word caused by one input word.
// csr_*: write-only registers, index 0..5 = delim_a, delim_b, delim_c,
//   delim_d, delim_count, quote_char; write only while the block is idle.
// Path: an accepted word's results are written into the queue, then loaded
//   into the output register when it is empty or its word is taken.
// Throughput: one input word per cycle while the queue has room; the output
//   register delivers one result word per cycle while rsp_chan is ready,
//   so a word causing two results yields two result words, absorbed by
//   the QUEUE_DEPTH-entry queue between front and back.
// Reset (synchronous, active high) restores register defaults, empties the
//   queue and returns the scanner to skipping delimiters.
// A stalled receiver holds the output word; req_chan.ready drops only when
//   the queue is full.

module quoted_token_splitter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   qts_req_if.sink                         req_chan,
   qts_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [qts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qts_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import qts_pkg::*;

   logic         queue_ready, push_valid, head_valid, pop;
   entry_type    push_entry, head_entry;
   logic         front_ready;
   logic         rsp_valid, rsp_last;
   rsp_word_type rsp_word;

   // Classify bytes and run the scanner
   qts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_chan.valid),
      .text_byte   (req_chan.text_byte),
      .string_end  (req_chan.string_end),
      .req_ready   (front_ready),
      .queue_ready (queue_ready),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // Hold pending items
   qts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // Emit result words
   qts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .rsp_last   (rsp_last)
   );

   assign req_chan.ready        = front_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.token_byte   = rsp_word.token_byte;
   assign rsp_chan.byte_valid   = rsp_word.byte_valid;
   assign rsp_chan.token_end    = rsp_word.token_end;
   assign rsp_chan.last_of_item = rsp_last;

endmodule
